// ===== rtl/tsvf_pkg.sv =====
`default_nettype none
package tsvf_pkg;

  localparam int COUNT_DIGITS_DEF = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 2;
  localparam int BODY_MAX = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_MODE      = 3'd0,
    REG_SQUEEZE_BLANK    = 3'd1,
    REG_SHOW_ENDS        = 3'd2,
    REG_SHOW_TABS        = 3'd3,
    REG_SHOW_NONPRINTING = 3'd4
  } reg_index_t;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_MINUS  = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_HI_END = 8'd159;
  localparam logic [7:0] CH_META   = 8'd160;
  localparam logic [7:0] CH_TOP    = 8'd255;
  localparam logic [7:0] CTRL_OFS  = 8'd64;
  localparam logic [7:0] META_OFS  = 8'd128;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic [BODY_MAX-1:0][7:0] bytes;
    logic [2:0]               len;
  } body_t;

  typedef struct packed {
    logic  num_en;
    body_t body;
  } job_hdr_t;

  function automatic body_t body_decode(input logic [7:0] ch, input cfg_t cfg);
    body_t b;
    b.bytes = '0;
    b.len = 3'd1;
    b.bytes[0] = ch;
    if (ch == CH_NL) begin
      if (cfg.show_ends) begin
        b.bytes[0] = CH_DOLLAR;
        b.bytes[1] = CH_NL;
        b.len = 3'd2;
      end
    end else if (ch == CH_TAB) begin
      if (cfg.show_tabs) begin
        b.bytes[0] = CH_CARET;
        b.bytes[1] = CH_I;
        b.len = 3'd2;
      end
    end else if (cfg.show_nonprinting) begin
      if (ch < CH_SPACE && ch != CH_FF) begin
        b.bytes[0] = CH_CARET;
        b.bytes[1] = ch + CTRL_OFS;
        b.len = 3'd2;
      end else if (ch >= META_OFS && ch <= CH_HI_END) begin
        b.bytes[0] = CH_M;
        b.bytes[1] = CH_MINUS;
        b.bytes[2] = CH_CARET;
        b.bytes[3] = ch - CTRL_OFS;
        b.len = 3'd4;
      end else if (ch == CH_DEL) begin
        b.bytes[0] = CH_CARET;
        b.bytes[1] = CH_QMARK;
        b.len = 3'd2;
      end else if (ch >= CH_META && ch != CH_TOP) begin
        b.bytes[0] = CH_M;
        b.bytes[1] = CH_MINUS;
        b.bytes[2] = ch - META_OFS;
        b.len = 3'd3;
      end else if (ch == CH_TOP) begin
        b.bytes[0] = CH_M;
        b.bytes[1] = CH_MINUS;
        b.bytes[2] = CH_CARET;
        b.bytes[3] = CH_QMARK;
        b.len = 3'd4;
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/text_stream_visible_formatter_top.sv =====
// Visible text-stream formatter: numbering, blank-line squeezing, end and
// tab marks, caret and M- notation for control and high bytes.
// Input channel: in_valid/in_ready with data_byte and file_start; one word
// is one raw byte. Output channel: out_valid/out_ready with out_byte and
// last_of_run, which marks the final output word caused by an input word.
// A squeezed empty line gives no output word at all.
// Configuration: write cfg_index/cfg_data with cfg_wr_en high, only while
// the block is idle; indexes beyond the register list are ignored.
// The first output word of an input word goes through the job register
// and the output register. Throughput: one output word per cycle while
// out_ready is high, set by the single output register; an input word
// expanding to N words holds the job slot until its last goes, so plain
// bytes flow at one per cycle; a line number adds COUNT_DIGITS + 1 words.
// A new input word is taken while the previous output word waits: the job
// register and the output register decouple the two sides.
// When the receiver stalls, the output word holds and the job slot fills,
// then in_ready drops. Reset clears configuration, line count and line
// state, and empties both stages.
`default_nettype none
module text_stream_visible_formatter_top #(
  parameter int COUNT_DIGITS = tsvf_pkg::COUNT_DIGITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tsvf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tsvf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            file_start,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [7:0]                           out_byte,
  output logic                                 last_of_run
);

  tsvf_pkg::cfg_t           cfg;
  logic                     job_valid;
  tsvf_pkg::job_hdr_t       job_hdr;
  logic [4*COUNT_DIGITS-1:0] job_count;
  logic                     job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsvf_pkg::REG_NUMBER_MODE:      cfg.number_mode <= cfg_data;
        tsvf_pkg::REG_SQUEEZE_BLANK:    cfg.squeeze_blank <= cfg_data[0];
        tsvf_pkg::REG_SHOW_ENDS:        cfg.show_ends <= cfg_data[0];
        tsvf_pkg::REG_SHOW_TABS:        cfg.show_tabs <= cfg_data[0];
        tsvf_pkg::REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tsvf_front #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .file_start(file_start),
    .job_valid (job_valid),
    .job_hdr   (job_hdr),
    .job_count (job_count),
    .job_done  (job_done)
  );

  tsvf_emit #(
    .COUNT_DIGITS(COUNT_DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (job_valid),
    .job_hdr    (job_hdr),
    .job_count  (job_count),
    .job_done   (job_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

endmodule
`default_nettype wire

// ===== rtl/tsvf_front.sv =====
`default_nettype none
module tsvf_front #(
  parameter int COUNT_DIGITS = tsvf_pkg::COUNT_DIGITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tsvf_pkg::cfg_t            cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      file_start,
  output logic                           job_valid,
  output tsvf_pkg::job_hdr_t             job_hdr,
  output logic [4*COUNT_DIGITS-1:0]      job_count,
  input  wire logic                      job_done
);

  localparam int CW = 4 * COUNT_DIGITS;

  logic          prev_was_newline;
  logic          carried_was_newline;
  logic          blank_seen;
  logic [CW-1:0] line_count;

  logic          accept;
  logic          pnl;
  logic          bs;
  logic          is_nl;
  logic          drop;
  logic          num_en;
  logic          blank_seen_next;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] line_count_next;
  logic          all_nine;
  logic          carry;

  assign in_ready = !job_valid || job_done;
  assign accept = in_valid && in_ready;

  always_comb begin
    pnl = file_start ? carried_was_newline : prev_was_newline;
    bs = file_start ? 1'b0 : blank_seen;
    is_nl = (data_byte == tsvf_pkg::CH_NL);
    drop = pnl && cfg.squeeze_blank && is_nl && bs;
    blank_seen_next = (pnl && cfg.squeeze_blank) ? is_nl : bs;
    num_en = pnl && (cfg.number_mode != 2'd0) && (!cfg.number_mode[1] || !is_nl);
  end

  always_comb begin
    all_nine = 1'b1;
    carry = 1'b1;
    count_inc = line_count;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (line_count[4*i +: 4] != 4'd9) all_nine = 1'b0;
      if (carry) begin
        if (line_count[4*i +: 4] >= 4'd9) begin
          count_inc[4*i +: 4] = 4'd0;
        end else begin
          count_inc[4*i +: 4] = line_count[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    line_count_next = (num_en && !all_nine) ? count_inc : line_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_newline <= 1'b1;
      carried_was_newline <= 1'b1;
      blank_seen <= 1'b0;
      line_count <= '0;
      job_valid <= 1'b0;
    end else begin
      if (accept) begin
        blank_seen <= blank_seen_next;
        if (drop) begin
          prev_was_newline <= pnl;
        end else begin
          prev_was_newline <= is_nl;
          carried_was_newline <= is_nl;
          line_count <= line_count_next;
        end
        job_valid <= !drop;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      job_hdr.num_en <= num_en;
      job_hdr.body <= tsvf_pkg::body_decode(data_byte, cfg);
      job_count <= line_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tsvf_emit.sv =====
`default_nettype none
module tsvf_emit #(
  parameter int COUNT_DIGITS = tsvf_pkg::COUNT_DIGITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      job_valid,
  input  wire tsvf_pkg::job_hdr_t        job_hdr,
  input  wire logic [4*COUNT_DIGITS-1:0] job_count,
  output logic                           job_done,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_byte,
  output logic                           last_of_run
);

  localparam int POS_W = $clog2(COUNT_DIGITS + 6);
  localparam logic [POS_W-1:0] TAB_POS = POS_W'(COUNT_DIGITS);
  localparam logic [POS_W-1:0] BODY_POS = POS_W'(COUNT_DIGITS + 1);

  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        eff;
  logic [POS_W-1:0]        bidx;
  logic                    last;
  logic                    step;
  logic [7:0]              byte_sel;
  logic [COUNT_DIGITS-1:0] blank_digit;
  logic                    zero_above;

  assign step = job_valid && (!out_valid || out_ready);
  assign job_done = step && last;

  always_comb begin
    eff = job_hdr.num_en ? pos : pos + BODY_POS;
    bidx = eff - BODY_POS;
    last = (eff == BODY_POS + POS_W'(job_hdr.body.len) - POS_W'(1));
  end

  always_comb begin
    zero_above = 1'b1;
    for (int i = COUNT_DIGITS - 1; i >= 0; i--) begin
      zero_above = zero_above && (job_count[4*i +: 4] == 4'd0);
      blank_digit[i] = zero_above && (i != 0);
    end
  end

  always_comb begin
    byte_sel = job_hdr.body.bytes[bidx[1:0]];
    if (eff == TAB_POS) begin
      byte_sel = tsvf_pkg::CH_TAB;
    end else if (eff < TAB_POS) begin
      for (int i = 0; i < COUNT_DIGITS; i++) begin
        if (eff == POS_W'(COUNT_DIGITS - 1 - i)) begin
          byte_sel = blank_digit[i] ? tsvf_pkg::CH_SPACE
                                    : (tsvf_pkg::CH_ZERO | {4'h0, job_count[4*i +: 4]});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        pos <= last ? '0 : pos + POS_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_byte <= byte_sel;
      last_of_run <= last;
    end
  end

endmodule
`default_nettype wire
